// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the sphere tessellator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define USPH_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define USPH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/usph_pkg.sv -----
// ---------------------------------------------------------------------------
// usph_pkg
// Shared constants, types and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package usph_pkg;

    localparam int ANG_W     = 16;   // binary angle width
    localparam int CRD_W     = 16;   // coordinate width, Q1.15
    localparam int FRAC      = CRD_W - 1;
    localparam int STEPS     = 16;   // CORDIC rotations
    localparam int CNT_W     = 8;    // sector / stack count width
    localparam int RAD_W     = 15;
    localparam int IDX_W     = 16;
    localparam int CW        = 33;   // CORDIC working width
    localparam int WORK_FRAC = 30;
    localparam int RCP_W     = 32;   // reciprocal width
    localparam int QDEPTH    = 32;
    localparam int QPTR_W    = 5;
    localparam int QCNT_W    = 6;

    localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QDEPTH);
    localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 33'sd652032874;

    localparam logic [1:0] CFG_RADIUS  = 2'd0;
    localparam logic [1:0] CFG_SECTORS = 2'd1;
    localparam logic [1:0] CFG_STACKS  = 2'd2;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_TRI    = 2'd1;
    localparam logic [1:0] KIND_OOR    = 2'd2;

    typedef struct packed {
        logic             oor;
        logic             up;
        logic             down;
        logic [IDX_W-1:0] k1;
        logic [IDX_W-1:0] k2;
    } t_side;

    typedef struct packed {
        t_side            side;
        logic [CRD_W-1:0] px;
        logic [CRD_W-1:0] py;
        logic [CRD_W-1:0] pz;
    } t_vtx;

    // round(atan(2^-k) * 2^32 / (2*pi))
    function automatic logic signed [CW-1:0] atan_lut(input int k);
        logic signed [CW-1:0] v;
        case (k)
            0:  v = 33'sd536870912;
            1:  v = 33'sd316933406;
            2:  v = 33'sd167458907;
            3:  v = 33'sd85004756;
            4:  v = 33'sd42667331;
            5:  v = 33'sd21354465;
            6:  v = 33'sd10679838;
            7:  v = 33'sd5340245;
            8:  v = 33'sd2670163;
            9:  v = 33'sd1335087;
            10: v = 33'sd667544;
            11: v = 33'sd333772;
            12: v = 33'sd166886;
            13: v = 33'sd83443;
            14: v = 33'sd41722;
            15: v = 33'sd20861;
            16: v = 33'sd10430;
            17: v = 33'sd5215;
            18: v = 33'sd2608;
            19: v = 33'sd1304;
            20: v = 33'sd652;
            21: v = 33'sd326;
            22: v = 33'sd163;
            23: v = 33'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/usph_recip.sv -----
// ---------------------------------------------------------------------------
// usph_recip
// Serial restoring divider: o_recip = floor((2^32-1)/D) + 1, one bit a cycle.
// ---------------------------------------------------------------------------
module usph_recip
    import usph_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [CNT_W-1:0] i_div,
    output logic             o_busy,
    output logic [RCP_W-1:0] o_recip
);

    logic             r_busy;
    logic [4:0]       r_cnt;
    logic [CNT_W-1:0] r_div;
    logic [CNT_W-1:0] r_rem;
    logic [RCP_W-1:0] r_quo;
    logic [RCP_W-1:0] r_recip;

    logic [CNT_W:0]   w_trial;
    logic             w_ge;
    logic [CNT_W-1:0] n_rem;
    logic [RCP_W-1:0] n_quo;

    // dividend is all ones, so the shifted-in bit is always 1
    assign w_trial = {r_rem, 1'b1};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign n_rem   = w_ge ? CNT_W'(w_trial - {1'b0, r_div}) : w_trial[CNT_W-1:0];
    assign n_quo   = {r_quo[RCP_W-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_div <= i_div;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            if (r_cnt == 5'd31) begin
                r_recip <= n_quo + RCP_W'(1);
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_recip = r_recip;

endmodule

// ----- rtl/usph_cordic.sv -----
// ---------------------------------------------------------------------------
// usph_cordic
// Two-lane pipelined rotation CORDIC: sine and cosine of binary angles.
// ---------------------------------------------------------------------------
module usph_cordic
    import usph_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_side                 i_side,
    input  logic [1:0][ANG_W-1:0] i_ang,
    output logic                  o_valid,
    output t_side                 o_side,
    output logic [1:0][CRD_W-1:0] o_sin,
    output logic [1:0][CRD_W-1:0] o_cos
);

    logic                 r_v    [STEPS+1];
    t_side                r_side [STEPS+1];
    logic signed [CW-1:0] r_x    [STEPS+1][2];
    logic signed [CW-1:0] r_y    [STEPS+1][2];
    logic signed [CW-1:0] r_z    [STEPS+1][2];
    logic                 r_flip [STEPS+1][2];

    logic                  r_ov;
    t_side                 r_oside;
    logic [1:0][CRD_W-1:0] r_sin;
    logic [1:0][CRD_W-1:0] r_cos;

    function automatic logic [CRD_W-1:0] to_coord(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] s;
        logic [CRD_W-1:0]     r;
        s = v >>> (WORK_FRAC - FRAC);
        if (s > CW'(32767)) begin
            r = 16'h7fff;
        end else if (s < -CW'(32768)) begin
            r = 16'h8000;
        end else begin
            r = s[CRD_W-1:0];
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
    end

    // fold quadrants 1 and 2 by a half turn, negate at the end
    for (genvar l = 0; l < 2; l++) begin : g_fold
        logic [31:0] w_a;
        logic [31:0] w_af;
        logic        w_flip;
        assign w_a    = {i_ang[l], {(32-ANG_W){1'b0}}};
        assign w_flip = (w_a[31:30] == 2'd1) || (w_a[31:30] == 2'd2);
        assign w_af   = w_flip ? (w_a - 32'h8000_0000) : w_a;
        always_ff @(posedge i_clk) begin
            r_x[0][l]    <= CORDIC_GAIN_INV;
            r_y[0][l]    <= '0;
            r_z[0][l]    <= signed'({w_af[31], w_af});
            r_flip[0][l] <= w_flip;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end
        always_ff @(posedge i_clk) begin
            r_side[k+1] <= r_side[k];
        end
        for (genvar l = 0; l < 2; l++) begin : g_lane
            always_ff @(posedge i_clk) begin
                r_flip[k+1][l] <= r_flip[k][l];
                if (!r_z[k][l][CW-1]) begin
                    r_x[k+1][l] <= r_x[k][l] - (r_y[k][l] >>> k);
                    r_y[k+1][l] <= r_y[k][l] + (r_x[k][l] >>> k);
                    r_z[k+1][l] <= r_z[k][l] - atan_lut(k);
                end else begin
                    r_x[k+1][l] <= r_x[k][l] + (r_y[k][l] >>> k);
                    r_y[k+1][l] <= r_y[k][l] - (r_x[k][l] >>> k);
                    r_z[k+1][l] <= r_z[k][l] + atan_lut(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[STEPS];
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_out
        always_ff @(posedge i_clk) begin
            r_cos[l] <= to_coord(r_flip[STEPS][l] ? -r_x[STEPS][l] : r_x[STEPS][l]);
            r_sin[l] <= to_coord(r_flip[STEPS][l] ? -r_y[STEPS][l] : r_y[STEPS][l]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_oside <= r_side[STEPS];
    end

    assign o_valid = r_ov;
    assign o_side  = r_oside;
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

// ----- rtl/usph_queue.sv -----
// ---------------------------------------------------------------------------
// usph_queue
// Vertex queue and result sequencer: one cell in, up to three results out.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module usph_queue
    import usph_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_vtx             i_vtx,
    output logic             o_pop,
    output logic             o_strobe,
    output logic [1:0]       o_kind,
    output logic [CRD_W-1:0] o_pos_x,
    output logic [CRD_W-1:0] o_pos_y,
    output logic [CRD_W-1:0] o_pos_z,
    output logic [IDX_W-1:0] o_index_a,
    output logic [IDX_W-1:0] o_index_b,
    output logic [IDX_W-1:0] o_index_c,
    output logic             o_last
);

    typedef enum logic [1:0] {PH_VERT, PH_UP, PH_DOWN} t_phase;

    t_vtx              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    t_phase            r_phase;

    logic             r_strobe;
    logic [1:0]       r_kind;
    logic [CRD_W-1:0] r_px, r_py, r_pz;
    logic [IDX_W-1:0] r_ia, r_ib, r_ic;
    logic             r_last;

    t_vtx             w_head;
    logic             w_emit;
    logic             w_pop;
    t_phase           n_phase;
    logic [1:0]       n_kind;
    logic [CRD_W-1:0] n_px, n_py, n_pz;
    logic [IDX_W-1:0] n_ia, n_ib, n_ic;
    logic             n_last;

    assign w_head = r_mem[r_rd];
    assign w_emit = (r_count != '0);

    always_comb begin
        n_phase = r_phase;
        n_kind  = KIND_VERTEX;
        n_px    = '0;
        n_py    = '0;
        n_pz    = '0;
        n_ia    = '0;
        n_ib    = '0;
        n_ic    = '0;
        n_last  = 1'b0;
        w_pop   = 1'b0;
        if (w_emit) begin
            unique case (r_phase)
                PH_VERT: begin
                    if (w_head.side.oor) begin
                        n_kind = KIND_OOR;
                        n_last = 1'b1;
                    end else begin
                        n_px   = w_head.px;
                        n_py   = w_head.py;
                        n_pz   = w_head.pz;
                        n_last = !w_head.side.up && !w_head.side.down;
                    end
                    if (n_last) begin
                        w_pop = 1'b1;
                    end else begin
                        n_phase = w_head.side.up ? PH_UP : PH_DOWN;
                    end
                end
                PH_UP: begin
                    n_kind = KIND_TRI;
                    n_ia   = w_head.side.k1;
                    n_ib   = w_head.side.k2;
                    n_ic   = w_head.side.k1 + IDX_W'(1);
                    n_last = !w_head.side.down;
                    if (n_last) begin
                        w_pop   = 1'b1;
                        n_phase = PH_VERT;
                    end else begin
                        n_phase = PH_DOWN;
                    end
                end
                PH_DOWN: begin
                    n_kind  = KIND_TRI;
                    n_ia    = w_head.side.k1 + IDX_W'(1);
                    n_ib    = w_head.side.k2;
                    n_ic    = w_head.side.k2 + IDX_W'(1);
                    n_last  = 1'b1;
                    w_pop   = 1'b1;
                    n_phase = PH_VERT;
                end
                default: begin
                    n_phase = PH_VERT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_vtx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_VERT;
            r_wr     <= '0;
            r_rd     <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_strobe <= w_emit;
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(w_pop);
        end
        r_kind <= n_kind;
        r_px   <= n_px;
        r_py   <= n_py;
        r_pz   <= n_pz;
        r_ia   <= n_ia;
        r_ib   <= n_ib;
        r_ic   <= n_ic;
        r_last <= n_last;
    end

    assign o_pop     = w_pop;
    assign o_strobe  = r_strobe;
    assign o_kind    = r_kind;
    assign o_pos_x   = r_px;
    assign o_pos_y   = r_py;
    assign o_pos_z   = r_pz;
    assign o_index_a = r_ia;
    assign o_index_b = r_ib;
    assign o_index_c = r_ic;
    assign o_last    = r_last;

    `USPH_ASSERT(a_q_no_overflow, i_clk, i_rst_n, i_push |-> (r_count != QFULL) || w_pop, "queue overflow")
    `USPH_ASSERT(a_q_oor_last, i_clk, i_rst_n, (r_strobe && (r_kind == KIND_OOR)) |-> r_last, "out-of-range result not last")

endmodule

// ----- rtl/uv_sphere_tessellator_core.sv -----
// A cell runs stage 0, stage 1, the CORDIC, M1, M2 and the queue to its first strobe.
// Throughput: one cell per cycle while results keep pace and no divider runs;
//   each cell gives one to three results, one per cycle, credit window of 32 cells.
// Reset: synchronous, active low; loads radius 16384, 36 sectors, 18 stacks,
//   then busy stays high while the reciprocal dividers run; the same pass
//   follows every sector or stack count write. Results cannot stall.
// ---------------------------------------------------------------------------
// uv_sphere_tessellator_core
// Latitude/longitude sphere tessellator: vertex position and triangle
// indices for one grid cell per item.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module uv_sphere_tessellator_core
    import usph_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // config write port
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [RAD_W-1:0] i_cfg_data,
    // item in
    input  logic             start,
    output logic             busy,
    input  logic [CNT_W-1:0] i_stack_index,
    input  logic [CNT_W-1:0] i_sector_index,
    // results
    output logic             o_strobe,
    output logic [1:0]       o_kind,
    output logic [CRD_W-1:0] o_pos_x,
    output logic [CRD_W-1:0] o_pos_y,
    output logic [CRD_W-1:0] o_pos_z,
    output logic [IDX_W-1:0] o_index_a,
    output logic [IDX_W-1:0] o_index_b,
    output logic [IDX_W-1:0] o_index_c,
    output logic             o_last
);

    // ---------------- configuration ----------------
    logic [RAD_W-1:0] r_radius;
    logic [CNT_W-1:0] r_sectors;
    logic [CNT_W-1:0] r_stacks;
    logic             r_div_pend;   // kick the reciprocal pass next cycle

    logic [CNT_W-1:0] w_s;          // counts clamped to their minimum
    logic [CNT_W-1:0] w_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= RAD_W'(16384);
            r_sectors  <= CNT_W'(36);
            r_stacks   <= CNT_W'(18);
            r_div_pend <= 1'b1;
        end else begin
            r_div_pend <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RADIUS: r_radius <= i_cfg_data;
                    CFG_SECTORS: begin
                        r_sectors  <= i_cfg_data[CNT_W-1:0];
                        r_div_pend <= 1'b1;
                    end
                    CFG_STACKS: begin
                        r_stacks   <= i_cfg_data[CNT_W-1:0];
                        r_div_pend <= 1'b1;
                    end
                    default: ;  // unknown register, ignored
                endcase
            end
        end
    end

    assign w_s = (r_sectors < CNT_W'(3)) ? CNT_W'(3) : r_sectors;
    assign w_t = (r_stacks < CNT_W'(2)) ? CNT_W'(2) : r_stacks;

    // Reciprocals replace the angle divisions: floor(n/D) = (n*R) >> 32 with
    // R = ceil(2^32/D), exact for n < 2^24.
    logic             w_rs_busy, w_rt_busy;
    logic [RCP_W-1:0] w_rs, w_rt;

    usph_recip u_recip_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_div_pend),
        .i_div   (w_s),
        .o_busy  (w_rs_busy),
        .o_recip (w_rs)
    );

    usph_recip u_recip_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_div_pend),
        .i_div   (w_t),
        .o_busy  (w_rt_busy),
        .o_recip (w_rt)
    );

    // ---------------- credit: cells accepted but not yet retired ----------------
    logic              r_used[1];
    logic [QCNT_W-1:0] r_credit;
    logic              w_acc;
    logic              w_pop;

    assign busy  = r_div_pend || w_rs_busy || w_rt_busy || (r_credit == QFULL);
    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit  <= '0;
            r_used[0] <= 1'b0;
        end else begin
            r_credit  <= r_credit + QCNT_W'(w_acc) - QCNT_W'(w_pop);
            r_used[0] <= w_acc;
        end
    end

    // ---------------- stage 0: input register ----------------
    logic [CNT_W-1:0] r0_i, r0_j;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r0_i <= i_stack_index;
            r0_j <= i_sector_index;
        end
    end

    // ---------------- stage 1: angle products, cell class, indices ----------------
    logic                   r1_v;
    t_side                  r1_side;
    logic [ANG_W-1:0]       r1_sec_ang;
    logic [ANG_W-1:0]       r1_stk_q;

    logic [CNT_W+RCP_W-1:0] w_pj, w_pi;
    logic [2*CNT_W:0]       w_row;
    logic [IDX_W-1:0]       w_k1;
    logic                   w_inside;
    t_side                  w_side;

    assign w_pj     = {{CNT_W{1'b0}}, w_rs} * {{RCP_W{1'b0}}, r0_j};
    assign w_pi     = {{CNT_W{1'b0}}, w_rt} * {{RCP_W{1'b0}}, r0_i};
    assign w_row    = (2*CNT_W+1)'(r0_i) * (2*CNT_W+1)'({1'b0, w_s} + 9'd1);
    assign w_k1     = IDX_W'(w_row + (2*CNT_W+1)'(r0_j));
    assign w_inside = (r0_i < w_t) && (r0_j < w_s);

    always_comb begin
        w_side.oor  = (r0_i > w_t) || (r0_j > w_s);
        w_side.up   = w_inside && (r0_i != '0);
        w_side.down = w_inside && (r0_i != w_t - CNT_W'(1));
        w_side.k1   = w_k1;
        w_side.k2   = w_k1 + IDX_W'(w_s) + IDX_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r_used[0];
        end
        r1_side    <= w_side;
        r1_sec_ang <= w_pj[31:16];          // j*65536/S
        r1_stk_q   <= w_pi[32:17];          // i*32768/T
    end

    // ---------------- CORDIC: lane 0 stack angle, lane 1 sector angle ----------------
    logic [1:0][ANG_W-1:0] w_ang;
    logic                  w_cv;
    t_side                 w_cside;
    logic [1:0][CRD_W-1:0] w_sin, w_cos;

    assign w_ang[0] = ANG_W'(16384) - r1_stk_q;
    assign w_ang[1] = r1_sec_ang;

    usph_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_v),
        .i_side  (r1_side),
        .i_ang   (w_ang),
        .o_valid (w_cv),
        .o_side  (w_cside),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // ---------------- M1: radius scaling ----------------
    logic                    rm1_v;
    t_side                   rm1_side;
    logic signed [CRD_W-1:0] rm1_xy, rm1_pz, rm1_sc, rm1_ss;
    logic signed [2*CRD_W-1:0] w_pxy, w_ppz;

    assign w_pxy = signed'({1'b0, r_radius}) * signed'(w_cos[0]);
    assign w_ppz = signed'({1'b0, r_radius}) * signed'(w_sin[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm1_v <= 1'b0;
        end else begin
            rm1_v <= w_cv;
        end
        rm1_side <= w_cside;
        rm1_xy   <= w_pxy[FRAC+CRD_W-1:FRAC];
        rm1_pz   <= w_ppz[FRAC+CRD_W-1:FRAC];
        rm1_sc   <= w_cos[1];
        rm1_ss   <= w_sin[1];
    end

    // ---------------- M2: ring projection ----------------
    logic                      rm2_v;
    t_vtx                      rm2_vtx;
    logic signed [2*CRD_W-1:0] w_ppx, w_ppy;

    assign w_ppx = rm1_xy * rm1_sc;
    assign w_ppy = rm1_xy * rm1_ss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm2_v <= 1'b0;
        end else begin
            rm2_v <= rm1_v;
        end
        rm2_vtx.side <= rm1_side;
        rm2_vtx.px   <= w_ppx[FRAC+CRD_W-1:FRAC];
        rm2_vtx.py   <= w_ppy[FRAC+CRD_W-1:FRAC];
        rm2_vtx.pz   <= rm1_pz;
    end

    // ---------------- result queue and sequencer ----------------
    usph_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (rm2_v),
        .i_vtx     (rm2_vtx),
        .o_pop     (w_pop),
        .o_strobe  (o_strobe),
        .o_kind    (o_kind),
        .o_pos_x   (o_pos_x),
        .o_pos_y   (o_pos_y),
        .o_pos_z   (o_pos_z),
        .o_index_a (o_index_a),
        .o_index_b (o_index_b),
        .o_index_c (o_index_c),
        .o_last    (o_last)
    );

    `USPH_ASSERT(a_credit_bound, i_clk, i_rst_n, r_credit <= QFULL, "credit above depth")
    `USPH_ASSERT(a_accept_counts, i_clk, i_rst_n, w_acc |=> (r_credit != '0), "cell not counted")

endmodule
